[rtl/adf_pkg.sv]
`default_nettype none

package adf_pkg;

	// Default sizing
	localparam int BUF_DEPTH_DEF   = 32768;
	localparam int SAMPLE_BITS_DEF = 24;

	// Register widths
	localparam int DELAY_W    = 15;
	localparam int GAIN_W     = 16;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 8;

	// Gain is Q1.15: fractional bits and the rounding half LSB
	localparam int FRAC_BITS = 15;
	localparam int ROUND_HALF = 1 << (FRAC_BITS - 1);

	// Register map
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DELAY_SAMPLES = 8'd0,
		REG_GAIN          = 8'd1
	} cfg_reg_t;

endpackage : adf_pkg

`default_nettype wire

[rtl/adf_in_if.sv]
`default_nettype none

// Sample request channel
interface adf_in_if #(
	parameter int SAMPLE_BITS = 24
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_in;

	modport source (output valid, output sample_in, input ready);
	modport sink   (input valid, input sample_in, output ready);
endinterface : adf_in_if

`default_nettype wire

[rtl/adf_out_if.sv]
`default_nettype none

// Result request channel
interface adf_out_if #(
	parameter int SAMPLE_BITS = 24
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_out;

	modport source (output valid, output sample_out, input ready);
	modport sink   (input valid, input sample_out, output ready);
endinterface : adf_out_if

`default_nettype wire

[rtl/adf_arith.sv]
`default_nettype none

// Allpass arithmetic: y = sat(round(g*(yd - x) + xd)), three stages.
// Stage 1 takes the delayed samples from the memory read registers, zeroed where never written.
module adf_arith
	import adf_pkg::*;
#(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          adv,
	input  wire logic signed [GAIN_W-1:0]      gain,
	input  wire logic signed [SAMPLE_BITS-1:0] x_s1,
	input  wire logic signed [SAMPLE_BITS-1:0] xd_s1,
	input  wire logic signed [SAMPLE_BITS-1:0] yd_s1,
	output logic signed [SAMPLE_BITS-1:0]      y_s3
);

	localparam int SB  = SAMPLE_BITS;
	localparam int PW  = SB + 1 + GAIN_W;       // product width
	localparam int AW2 = PW + 1;                // accumulator width
	localparam int SW  = AW2 - FRAC_BITS;       // after the scale-down
	localparam int XPAD = AW2 - SB - FRAC_BITS; // sign bits above aligned xd

	logic signed [SB:0]    diff_s1;
	logic signed [SB:0]    diff_s2;
	logic signed [SB-1:0]  xd_s2;
	logic signed [PW-1:0]  prod_s2;
	logic signed [PW-1:0]  prod_s3;
	logic signed [SB-1:0]  xd_s3;
	logic [AW2-1:0]        acc_s3;
	logic [SW-1:0]         sh_s3;
	logic                  in_range_s3;

	// Stage 1: feedback minus input, one bit wider
	assign diff_s1 = {yd_s1[SB-1], yd_s1} - {x_s1[SB-1], x_s1};

	always_ff @(posedge clk) begin
		if (adv) begin
			diff_s2 <= diff_s1;
			xd_s2   <= xd_s1;
		end
	end

	// Stage 2: gain product, exact
	assign prod_s2 = gain * diff_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s3 <= prod_s2;
			xd_s3   <= xd_s2;
		end
	end

	// Stage 3: align xd, add half LSB, floor, saturate
	assign acc_s3 = {prod_s3[PW-1], prod_s3}
		+ {{XPAD{xd_s3[SB-1]}}, xd_s3, {FRAC_BITS{1'b0}}}
		+ AW2'(ROUND_HALF);
	assign sh_s3 = acc_s3[AW2-1:FRAC_BITS];
	assign in_range_s3 = (&sh_s3[SW-1:SB-1]) || !(|sh_s3[SW-1:SB-1]);

	always_comb begin
		if (in_range_s3) begin
			y_s3 = sh_s3[SB-1:0];
		end else if (sh_s3[SW-1]) begin
			y_s3 = {1'b1, {(SB-1){1'b0}}};
		end else begin
			y_s3 = {1'b0, {(SB-1){1'b1}}};
		end
	end

endmodule : adf_arith

`default_nettype wire

[rtl/allpass_delay_filter.sv]
// Schroeder allpass filter with a programmable delay. Each sample request
// gives one result y = -g*x + x[n-N] + g*y[n-N], rounded half up and
// saturated to SAMPLE_BITS. Past inputs and outputs live in two single-port-
// write, registered-read memories of BUF_DEPTH entries; after reset they read
// as zero until first written, tracked by the write pointer and a wrap flag,
// so no clearing pass is needed. The memory read happens at the edge that
// takes the request; subtract, multiply and round/saturate then follow, each
// ending in a register, the last of them the output register.
// A new sample is taken every cycle while the delay N is at least four; for N
// of one to three the read would hit an output still in the arithmetic
// pipeline, so the request waits until that output has been written back;
// for N = 1 each sample is written back before the next one is taken.
// A stalled result holds the whole pipeline and the input with it. Delay 0
// acts as 1 and a delay of BUF_DEPTH or more is clamped to BUF_DEPTH-1.
// Registers are meant to be written only while the filter is idle; writes
// to unknown indices are dropped.
`default_nettype none

module allpass_delay_filter
	import adf_pkg::*;
#(
	parameter int BUF_DEPTH   = BUF_DEPTH_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  wr_en,
	input  wire logic [CFG_IDX_W-1:0]  wr_index,
	input  wire logic [CFG_DATA_W-1:0] wr_data,
	adf_in_if.sink                     samples,
	adf_out_if.source                  results
);

	localparam int AW = $clog2(BUF_DEPTH);
	localparam int EW = 17;                // holds 2*BUF_DEPTH-2
	localparam int SB = SAMPLE_BITS;

	// Configuration
	logic [DELAY_W-1:0]       delay_q;
	logic signed [GAIN_W-1:0] gain_q;

	// Delay-line memories
	logic signed [SB-1:0] input_line  [BUF_DEPTH];
	logic signed [SB-1:0] output_line [BUF_DEPTH];

	// Pointer state
	logic [AW-1:0] wp_q;
	logic          wrapped_q;

	// Pipeline
	logic          valid_s1, valid_s2, valid_s3;
	logic [AW-1:0] wp_s1, wp_s2, wp_s3;
	logic          rd_ok_s1;
	logic signed [SB-1:0] x_s1;
	logic signed [SB-1:0] xd_mem_s1, yd_mem_s1;
	logic signed [SB-1:0] xd_s1, yd_s1;
	logic signed [SB-1:0] y_s3;

	// Output register
	logic                 out_valid_q;
	logic signed [SB-1:0] sample_out_q;

	logic          adv;
	logic          hazard;
	logic          accept;
	logic [EW-1:0] n_ext, n_eff, rp_sum, rp_wrap;
	logic [AW-1:0] rp;
	logic          rd_ok;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q <= DELAY_W'(1);
			gain_q  <= '0;
		end else if (wr_en) begin
			unique case (cfg_reg_t'(wr_index))
				REG_DELAY_SAMPLES: delay_q <= wr_data[DELAY_W-1:0];
				REG_GAIN:          gain_q  <= $signed(wr_data[GAIN_W-1:0]);
				default: ;
			endcase
		end
	end

	// Read address: clamp N, step back from the write pointer with wrap
	always_comb begin
		n_ext = EW'(delay_q);
		if (n_ext == '0) begin
			n_eff = EW'(1);
		end else if (n_ext >= EW'(BUF_DEPTH)) begin
			n_eff = EW'(BUF_DEPTH - 1);
		end else begin
			n_eff = n_ext;
		end
		rp_sum = EW'(wp_q) + EW'(BUF_DEPTH) - n_eff;
		if (rp_sum >= EW'(BUF_DEPTH)) begin
			rp_wrap = rp_sum - EW'(BUF_DEPTH);
		end else begin
			rp_wrap = rp_sum;
		end
		rp = rp_wrap[AW-1:0];
		// entries never written read as zero
		rd_ok = wrapped_q || (rp < wp_q);
	end

	// Interlock: output entry still on its way through the arithmetic
	assign hazard = (valid_s1 && (wp_s1 == rp))
		|| (valid_s2 && (wp_s2 == rp))
		|| (valid_s3 && (wp_s3 == rp));

	assign adv           = !out_valid_q || results.ready;
	assign samples.ready = adv && !hazard;
	assign accept        = samples.valid && samples.ready;

	// Input line: write new sample; read delayed input and output samples
	always_ff @(posedge clk) begin
		if (accept) begin
			input_line[wp_q] <= samples.sample_in;
			xd_mem_s1        <= input_line[rp];
			yd_mem_s1        <= output_line[rp];
		end
	end

	// Output line write-back from the last stage
	always_ff @(posedge clk) begin
		if (adv && valid_s3) begin
			output_line[wp_s3] <= y_s3;
		end
	end

	// Write pointer and wrap flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q      <= '0;
			wrapped_q <= 1'b0;
		end else if (accept) begin
			if (wp_q == AW'(BUF_DEPTH - 1)) begin
				wp_q      <= '0;
				wrapped_q <= 1'b1;
			end else begin
				wp_q <= wp_q + AW'(1);
			end
		end
	end

	// Stage valids and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s1    <= accept;
			valid_s2    <= valid_s1;
			valid_s3    <= valid_s2;
			out_valid_q <= valid_s3;
		end
	end

	// Stage payload
	always_ff @(posedge clk) begin
		if (adv) begin
			wp_s1        <= wp_q;
			rd_ok_s1     <= rd_ok;
			x_s1         <= samples.sample_in;
			wp_s2        <= wp_s1;
			wp_s3        <= wp_s2;
			sample_out_q <= y_s3;
		end
	end

	assign xd_s1 = rd_ok_s1 ? xd_mem_s1 : '0;
	assign yd_s1 = rd_ok_s1 ? yd_mem_s1 : '0;

	adf_arith #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_arith (
		.clk   (clk),
		.adv   (adv),
		.gain  (gain_q),
		.x_s1  (x_s1),
		.xd_s1 (xd_s1),
		.yd_s1 (yd_s1),
		.y_s3  (y_s3)
	);

	assign results.valid      = out_valid_q;
	assign results.sample_out = sample_out_q;

endmodule : allpass_delay_filter

`default_nettype wire
